// File: design/vsd_pkg.sv
// vsd_pkg: shared types and constants for the voice sample decoder
// holds the request queue entry, the operation codes and the arithmetic constants
// no dependencies
package vsd_pkg;

  localparam int FMT_W      = 4;
  localparam int COEF_REGS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SAMPLE_W   = 16;
  localparam int PART_W     = 15;
  localparam int NIB_TERM_W = 30;
  localparam int ACC_W      = 34;
  localparam int FRAC_SHIFT = 11;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_01 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_45 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_67 = 3'd4;

  // format register fields: bit 3 picks the adpcm/silent group, bit 2 the sample width
  localparam logic [1:0] FMT_CH_STEREO = 2'd2;

  // request function codes
  localparam logic FUNC_DECODE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  localparam logic signed [ACC_W-1:0]    RND_BIAS = 34'sd1024;
  localparam logic signed [ACC_W-1:0]    SAT_MAX  = 34'sd32767;
  localparam logic signed [ACC_W-1:0]    SAT_MIN  = -34'sd32768;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // request queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PCM,
    OP_ADPCM
  } vsd_op_t;

  // for OP_LOAD the two sample fields carry the new history
  typedef struct packed {
    vsd_op_t                        op;
    logic signed [SAMPLE_W-1:0]     left;
    logic signed [SAMPLE_W-1:0]     right;
    logic signed [NIB_TERM_W-1:0]   nib_term;
    logic signed [SAMPLE_W-1:0]     coef0;
    logic signed [SAMPLE_W-1:0]     coef1;
  } vsd_entry_t;

endpackage

// File: design/vsd_front.sv
// vsd_front: configuration registers and request classification
// turns each accepted request into a queue entry; uses vsd_pkg
module vsd_front import vsd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_func,
  input  logic [31:0]                  in_data_word,
  input  logic [7:0]                   in_frame_header,
  input  logic [3:0]                   in_frame_position,
  input  logic signed [SAMPLE_W-1:0]   in_history_recent,
  input  logic signed [SAMPLE_W-1:0]   in_history_older,
  output vsd_entry_t                   entry
);

  logic [FMT_W-1:0]      fmt_r;
  logic [CFG_DATA_W-1:0] coef_r [COEF_REGS];

  logic [2:0]                    coef_idx;
  logic [CFG_DATA_W-1:0]         coef_word;
  logic [3:0]                    nib;
  logic signed [NIB_TERM_W-1:0]  nib_ext;
  logic [4:0]                    nib_shift;
  logic signed [SAMPLE_W-1:0]    pcm8_lo, pcm8_hi, pcm16_lo, pcm16_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= '0;
      for (int i = 0; i < COEF_REGS; i++) coef_r[i] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FORMAT:  fmt_r     <= cfg_wdata[FMT_W-1:0];
        CFG_COEF_01: coef_r[0] <= cfg_wdata;
        CFG_COEF_23: coef_r[1] <= cfg_wdata;
        CFG_COEF_45: coef_r[2] <= cfg_wdata;
        CFG_COEF_67: coef_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign coef_idx  = in_frame_header[6:4];
  assign coef_word = coef_r[coef_idx[2:1]];
  assign nib       = in_frame_position[0] ? in_data_word[3:0] : in_data_word[7:4];
  assign nib_ext   = NIB_TERM_W'(signed'(nib));
  assign nib_shift = 5'(in_frame_header[3:0]) + 5'(FRAC_SHIFT);

  assign pcm8_lo  = signed'({in_data_word[7:0], 8'h00});
  assign pcm8_hi  = signed'({in_data_word[15:8], 8'h00});
  assign pcm16_lo = signed'(in_data_word[15:0]);
  assign pcm16_hi = signed'(in_data_word[31:16]);

  always_comb begin
    entry.op       = OP_PCM;
    entry.left     = '0;
    entry.right    = '0;
    entry.nib_term = nib_ext <<< nib_shift;
    entry.coef0    = signed'(coef_idx[0] ? coef_word[47:32] : coef_word[15:0]);
    entry.coef1    = signed'(coef_idx[0] ? coef_word[63:48] : coef_word[31:16]);
    if (in_func == FUNC_LOAD) begin
      entry.op    = OP_LOAD;
      entry.left  = in_history_recent;
      entry.right = in_history_older;
    end else if (!fmt_r[3]) begin
      // pcm group, bit 2 picks 16-bit samples
      if (fmt_r[2]) begin
        entry.left  = pcm16_lo;
        entry.right = (fmt_r[1:0] == FMT_CH_STEREO) ? pcm16_hi : pcm16_lo;
      end else begin
        entry.left  = pcm8_lo;
        entry.right = (fmt_r[1:0] == FMT_CH_STEREO) ? pcm8_hi : pcm8_lo;
      end
    end else if (!fmt_r[2] && fmt_r[1:0] != FMT_CH_STEREO) begin
      entry.op = OP_ADPCM;
    end
    // remaining codes are silent: pcm with zero samples
  end

endmodule

// File: design/vsd_queue.sv
// vsd_queue: short request queue between classification and execution
// four entries of vsd_entry_t; uses vsd_pkg
module vsd_queue import vsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  vsd_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output vsd_entry_t pop_entry
);

  localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

  vsd_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full      = (count_r == QFULL);
  assign not_empty = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

// File: design/vsd_back.sv
// vsd_back: executes queued requests, holds the adpcm history and the result register
// one multiply-add step per request; uses vsd_pkg
module vsd_back import vsd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  input  vsd_entry_t                q_entry,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [PART_W-1:0]  out_left_part,
  output logic signed [PART_W-1:0]  out_right_part
);

  logic signed [SAMPLE_W-1:0] hist_newest_r, hist_second_r;
  logic                       out_valid_r;
  logic signed [PART_W-1:0]   left_r, right_r;

  logic signed [31:0]          prod0, prod1;
  logic signed [ACC_W-1:0]     acc, acc_sh;
  logic signed [SAMPLE_W-1:0]  adpcm_val, res_left, res_right;

  function automatic logic signed [PART_W-1:0] halve(input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W:0] t;
    t = SAMPLE_W'(signed'(v)) + (SAMPLE_W+1)'(v[SAMPLE_W-1]);
    return t[SAMPLE_W-1:1];
  endfunction

  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  assign prod0  = 32'(q_entry.coef0) * 32'(hist_newest_r);
  assign prod1  = 32'(q_entry.coef1) * 32'(hist_second_r);
  assign acc    = ACC_W'(q_entry.nib_term) + ACC_W'(prod0) + ACC_W'(prod1) + RND_BIAS;
  assign acc_sh = acc >>> FRAC_SHIFT;

  always_comb begin
    if (acc_sh > SAT_MAX)      adpcm_val = SAMPLE_MAX;
    else if (acc_sh < SAT_MIN) adpcm_val = SAMPLE_MIN;
    else                       adpcm_val = acc_sh[SAMPLE_W-1:0];
  end

  assign res_left  = (q_entry.op == OP_ADPCM) ? adpcm_val : q_entry.left;
  assign res_right = (q_entry.op == OP_ADPCM) ? adpcm_val : q_entry.right;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_newest_r <= '0;
      hist_second_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        unique case (q_entry.op)
          OP_LOAD: begin
            hist_newest_r <= q_entry.left;
            hist_second_r <= q_entry.right;
          end
          OP_ADPCM: begin
            hist_newest_r <= adpcm_val;
            hist_second_r <= hist_newest_r;
          end
          default: ;
        endcase
        out_valid_r <= (q_entry.op != OP_LOAD);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.op != OP_LOAD) begin
      left_r  <= halve(res_left);
      right_r <= halve(res_right);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_part  = left_r;
  assign out_right_part = right_r;

endmodule

// File: design/voice_sample_decoder.sv
// voice_sample_decoder: an accepted request goes into the request queue, then into
// the output register, where out_valid rises; throughput one request per cycle
// while out_stall is low, set by the back end's combinational history multiply-add
// reset (synchronous, rst_n low) clears the format and coefficient registers,
// the adpcm history, the request queue and the output valid
module voice_sample_decoder import vsd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration writes
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [31:0]                 in_data_word,
  input  logic [7:0]                  in_frame_header,
  input  logic [3:0]                  in_frame_position,
  input  logic signed [SAMPLE_W-1:0]  in_history_recent,
  input  logic signed [SAMPLE_W-1:0]  in_history_older,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [PART_W-1:0]    out_left_part,
  output logic signed [PART_W-1:0]    out_right_part
);

  vsd_entry_t front_entry;
  vsd_entry_t q_entry;
  logic       q_full, q_not_empty, q_pop;
  logic       in_take;

  // front end: config registers, format decode, coefficient pick, nibble shift
  vsd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_func           (in_func),
    .in_data_word      (in_data_word),
    .in_frame_header   (in_frame_header),
    .in_frame_position (in_frame_position),
    .in_history_recent (in_history_recent),
    .in_history_older  (in_history_older),
    .entry             (front_entry)
  );

  // stall only when the queue is full, so the input never waits on the output
  // while there is room
  assign in_stall = q_full;
  assign in_take  = in_valid && !q_full;

  vsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_take),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_entry  (q_entry)
  );

  // back end: history update, adpcm multiply-add, saturation, halving,
  // output register that can be refilled while the result is being taken
  vsd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_part  (out_left_part),
    .out_right_part (out_right_part)
  );

endmodule

// File: design/vsd_checker.sv
// vsd_props: port-level assertions for the voice sample decoder
// bound to voice_sample_decoder below; uses vsd_pkg
module vsd_props import vsd_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [PART_W-1:0]    out_left_part,
  input logic signed [PART_W-1:0]    out_right_part
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_left_part) && $stable(out_right_part))
    else $error("result payload changed while stalled");

  // reset empties the output register and the queue
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // an offered result carries known bits
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_left_part, out_right_part}))
    else $error("result payload unknown");

endmodule

bind voice_sample_decoder vsd_props u_vsd_props (.*);

// File: sim/vsd_checker.sv
// vsd_checker: watches the request and result channels of voice_sample_decoder,
// predicts each decoded result and compares it field by field
// depends on vsd_pkg for the port widths, register indexes and function codes
module vsd_checker import vsd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_func,
  input  logic [31:0]                 in_data_word,
  input  logic [7:0]                  in_frame_header,
  input  logic [3:0]                  in_frame_position,
  input  logic signed [SAMPLE_W-1:0]  in_history_recent,
  input  logic signed [SAMPLE_W-1:0]  in_history_older,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [PART_W-1:0]    out_left_part,
  input  logic signed [PART_W-1:0]    out_right_part,
  output int                          mismatch_count,
  output int                          pending_count,
  output int                          results_checked
);

  typedef struct packed {
    logic signed [PART_W-1:0] left;
    logic signed [PART_W-1:0] right;
  } parts_t;

  parts_t expected_parts[$];

  logic [FMT_W-1:0]           fmt;
  logic [CFG_DATA_W-1:0]      coef_reg [COEF_REGS];
  logic signed [SAMPLE_W-1:0] hist_new;
  logic signed [SAMPLE_W-1:0] hist_old;

  // divide by two, rounding toward zero
  function automatic logic signed [PART_W-1:0] halve(input logic signed [SAMPLE_W-1:0] s);
    int v;
    v = s;
    v = v / 2;
    return v[PART_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] adpcm_sample(input logic [7:0] pair_byte,
                                                              input logic [7:0] hdr,
                                                              input logic [3:0] pos);
    logic [3:0]                 nib;
    logic [2:0]                 pair;
    logic [63:0]                pair_reg;
    logic signed [SAMPLE_W-1:0] c0;
    logic signed [SAMPLE_W-1:0] c1;
    int                         shamt;
    longint                     acc;
    nib      = pos[0] ? pair_byte[3:0] : pair_byte[7:4];
    pair     = hdr[6:4];
    pair_reg = coef_reg[pair[2:1]];
    {c1, c0} = pair[0] ? pair_reg[63:32] : pair_reg[31:0];
    shamt    = hdr[3:0] + FRAC_SHIFT;
    acc = (longint'($signed(nib)) <<< shamt) + longint'(c0) * longint'(hist_new)
        + longint'(c1) * longint'(hist_old);
    // arithmetic shift floors, as the rounding wants
    acc = (acc + 1024) >>> FRAC_SHIFT;
    if (acc > longint'(SAMPLE_MAX)) acc = SAMPLE_MAX;
    if (acc < longint'(SAMPLE_MIN)) acc = SAMPLE_MIN;
    return acc[SAMPLE_W-1:0];
  endfunction

  // works out the parts of one decode request, moving the history on for adpcm
  function automatic parts_t decode_request(input logic [31:0] data, input logic [7:0] hdr,
                                            input logic [3:0] pos);
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    logic signed [SAMPLE_W-1:0] s;
    logic                       stereo;
    parts_t                     p;
    l = '0;
    r = '0;
    stereo = (fmt[1:0] == FMT_CH_STEREO);
    if (!fmt[3]) begin
      if (fmt[2]) begin
        l = data[15:0];
        r = stereo ? data[31:16] : data[15:0];
      end else begin
        l = {data[7:0], 8'h00};
        r = stereo ? {data[15:8], 8'h00} : {data[7:0], 8'h00};
      end
    end else if (!fmt[2] && !stereo) begin
      s = adpcm_sample(data[7:0], hdr, pos);
      hist_old = hist_new;
      hist_new = s;
      l = s;
      r = s;
    end
    p.left  = halve(l);
    p.right = halve(r);
    return p;
  endfunction

  always @(posedge clk) begin : watch
    parts_t want;
    if (!rst_n) begin
      fmt      = '0;
      hist_new = '0;
      hist_old = '0;
      for (int k = 0; k < COEF_REGS; k++) coef_reg[k] = '0;
      expected_parts.delete();
      mismatch_count  = 0;
      results_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_parts.size() == 0) begin
          $error("result with no request waiting: left_part %0d, right_part %0d",
                 out_left_part, out_right_part);
          mismatch_count++;
        end else begin
          want = expected_parts.pop_front();
          results_checked++;
          if (out_left_part !== want.left) begin
            $error("left_part: expected %0d, got %0d", want.left, out_left_part);
            mismatch_count++;
          end
          if (out_right_part !== want.right) begin
            $error("right_part: expected %0d, got %0d", want.right, out_right_part);
            mismatch_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FORMAT:  fmt = cfg_wdata[FMT_W-1:0];
          CFG_COEF_01: coef_reg[0] = cfg_wdata;
          CFG_COEF_23: coef_reg[1] = cfg_wdata;
          CFG_COEF_45: coef_reg[2] = cfg_wdata;
          CFG_COEF_67: coef_reg[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_LOAD) begin
          hist_new = in_history_recent;
          hist_old = in_history_older;
        end else begin
          expected_parts.push_back(decode_request(in_data_word, in_frame_header,
                                                  in_frame_position));
        end
      end
    end
    pending_count = expected_parts.size();
  end

endmodule

// File: sim/tb_top.sv
// tb_top: stimulus and verdict for voice_sample_decoder
// drives requests, configuration writes and output stalls; vsd_checker does the checking
// depends on vsd_pkg, voice_sample_decoder and vsd_checker
module tb_top;
  import vsd_pkg::*;

  // format register codes used by the stimulus
  localparam logic [FMT_W-1:0] FMT_PCM8_MONO    = 4'd0;
  localparam logic [FMT_W-1:0] FMT_ADPCM        = 4'd8;
  localparam logic [FMT_W-1:0] FMT_ADPCM_ALIAS1 = 4'd9;
  localparam logic [FMT_W-1:0] FMT_ADPCM_ALIAS3 = 4'd11;

  localparam int PHASES         = 16;
  localparam int PHASE_REQUESTS = 95;
  localparam int HOLD_CYCLES    = 40;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LIMIT_CYCLES   = 300000;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_func;
  logic [31:0]                in_data_word;
  logic [7:0]                 in_frame_header;
  logic [3:0]                 in_frame_position;
  logic signed [SAMPLE_W-1:0] in_history_recent;
  logic signed [SAMPLE_W-1:0] in_history_older;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [PART_W-1:0]   out_left_part;
  logic signed [PART_W-1:0]   out_right_part;

  int   mismatch_count;
  int   pending_count;
  int   results_checked;
  int   items_sent;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_output;

  voice_sample_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_data_word      (in_data_word),
    .in_frame_header   (in_frame_header),
    .in_frame_position (in_frame_position),
    .in_history_recent (in_history_recent),
    .in_history_older  (in_history_older),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_part     (out_left_part),
    .out_right_part    (out_right_part)
  );

  vsd_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_data_word      (in_data_word),
    .in_frame_header   (in_frame_header),
    .in_frame_position (in_frame_position),
    .in_history_recent (in_history_recent),
    .in_history_older  (in_history_older),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_part     (out_left_part),
    .out_right_part    (out_right_part),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count),
    .results_checked   (results_checked)
  );

  // 12 unit period
  always #6 clk = ~clk;

  // result side: random stalls, or a solid hold while the pressure test runs
  always @(posedge clk) begin
    out_stall <= hold_output || ($urandom_range(99) < recv_stall_pct);
  end

  // overall limit, far beyond the slowest legal run
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("run limit reached with %0d results outstanding", pending_count);
    $display("Mismatches found");
    $finish;
  end

  // offers one request, with random idle cycles ahead of it, and waits for acceptance;
  // valid is only dropped on idle cycles so back-to-back requests keep it high
  task automatic send_request(input logic func, input logic [31:0] data,
                              input logic [7:0] hdr, input logic [3:0] pos,
                              input logic [15:0] h_new, input logic [15:0] h_old);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= func;
    in_data_word      <= data;
    in_frame_header   <= hdr;
    in_frame_position <= pos;
    in_history_recent <= h_new;
    in_history_older  <= h_old;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // history values: half the time audio-sized, otherwise anywhere in range
  function automatic logic [15:0] hist_value();
    if ($urandom_range(1) == 0) return 16'($urandom_range(8191) - 4096);
    return 16'($urandom);
  endfunction

  // coefficient words: typical fixed-point sizes, full range or the extremes
  function automatic logic [15:0] coef_word();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return ($urandom_range(1) == 0) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(8191) - 4096);
    endcase
  endfunction

  task automatic decode_item(input logic [31:0] data, input logic [7:0] hdr,
                             input logic [3:0] pos);
    send_request(FUNC_DECODE, data, hdr, pos, hist_value(), hist_value());
  endtask

  task automatic load_history(input logic [15:0] h_new, input logic [15:0] h_old);
    send_request(FUNC_LOAD, $urandom, 8'($urandom), 4'($urandom), h_new, h_old);
  endtask

  // write enable is dropped between register writes so it never toggles twice in a step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // idle the request side, let every result drain, then allow for a trailing load
  task automatic finish_phase();
    in_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // well-formed adpcm frame: history load then up to fourteen nibbles under one header;
  // now and then the load is skipped or the frame is cut short
  task automatic adpcm_frame();
    logic [7:0] hdr;
    logic [7:0] pair_byte;
    int         len;
    hdr = {4'($urandom), 4'($urandom_range(12))};
    len = ($urandom_range(9) == 0) ? $urandom_range(1, 13) : 14;
    pair_byte = 8'($urandom);
    if ($urandom_range(9) != 0) load_history(hist_value(), hist_value());
    for (int pos = 0; pos < len; pos++) begin
      // two nibbles share each byte, as in a real frame
      if (pos % 2 == 0) pair_byte = 8'($urandom);
      send_request(FUNC_DECODE, {24'($urandom), pair_byte}, hdr, 4'(pos),
                   hist_value(), hist_value());
    end
  endtask

  // unstructured request: any header, any position, occasional history load
  task automatic noise_request();
    send_request(($urandom_range(9) == 0) ? FUNC_LOAD : FUNC_DECODE, $urandom,
                 8'($urandom), 4'($urandom), hist_value(), hist_value());
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_coefs(input int ph);
    if (ph == 4)  return {4{16'h7FFF}};
    if (ph == 6)  return '0;
    if (ph == 10) return {4{16'h8000}};
    return {coef_word(), coef_word(), coef_word(), coef_word()};
  endfunction

  task automatic run_phase(input int ph);
    logic [FMT_W-1:0] code;
    logic             is_adpcm;
    int               start;
    // idle pattern for this phase
    case (ph % 4)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
    // even phases run adpcm, odd ones any format code at all
    is_adpcm = (ph % 2 == 0);
    if (is_adpcm) begin
      case ($urandom_range(2))
        0:       code = FMT_ADPCM;
        1:       code = FMT_ADPCM_ALIAS1;
        default: code = FMT_ADPCM_ALIAS3;
      endcase
    end else begin
      code = 4'($urandom_range(15));
      is_adpcm = (code == FMT_ADPCM || code == FMT_ADPCM_ALIAS1 || code == FMT_ADPCM_ALIAS3);
    end
    write_reg(CFG_FORMAT, CFG_DATA_W'(code));
    write_reg(CFG_COEF_01, pick_coefs(ph));
    write_reg(CFG_COEF_23, pick_coefs(ph));
    write_reg(CFG_COEF_45, pick_coefs(ph));
    write_reg(CFG_COEF_67, pick_coefs(ph));
    start = items_sent;
    while (items_sent - start < PHASE_REQUESTS) begin
      if (is_adpcm && $urandom_range(99) < 80) adpcm_frame();
      else noise_request();
    end
    finish_phase();
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_func           = FUNC_DECODE;
    in_data_word      = '0;
    in_frame_header   = '0;
    in_frame_position = '0;
    in_history_recent = '0;
    in_history_older  = '0;
    out_stall         = 1'b0;
    hold_output       = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    items_sent        = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: reset format first, pcm8 mono minimum with unused bits set
    decode_item(32'hFFFF_FF80, 8'h00, 4'd0);
    finish_phase();

    // pair 0 at the positive extreme, pair 1 at the negative, pair 2 unity gain on newest
    write_reg(CFG_COEF_01, {16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
    write_reg(CFG_COEF_23, {16'h0000, 16'h0000, 16'h0000, 16'h0800});

    // every format code with one word: odd negative and full-scale positive samples
    for (int code = 0; code < 16; code++) begin
      write_reg(CFG_FORMAT, CFG_DATA_W'(code));
      decode_item(32'h8001_7F80, 8'h00, 4'd0);
      finish_phase();
    end

    // adpcm corner cases
    write_reg(CFG_FORMAT, CFG_DATA_W'(FMT_ADPCM));
    load_history(16'h7FFF, 16'h7FFF);
    decode_item(32'h0000_0070, 8'h0F, 4'd0);   // largest nibble, largest scale: clips high
    decode_item(32'h0000_0007, 8'h1F, 4'd1);   // negative coefficients on full history: clips low
    load_history(16'h8000, 16'h8000);
    decode_item(32'h0000_0088, 8'h9F, 4'd14);  // pair index wraps; position fourteen is even
    decode_item(32'h0000_001F, 8'h20, 4'd15);  // position fifteen takes the low nibble
    decode_item(32'hFFFF_FFF0, 8'hF3, 4'd13);
    finish_phase();

    // long output hold while requests keep coming, so the queue fills and stalls input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output <= 1'b0;
      end
      begin
        adpcm_frame();
        adpcm_frame();
      end
    join
    finish_phase();

    // random part across formats, coefficient sets and idle patterns
    for (int ph = 0; ph < PHASES; ph++) run_phase(ph);

    $display("%0d requests sent and %0d results checked across all format codes,",
             items_sent, results_checked);
    $display("four idle patterns, extreme coefficients and a long output hold");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
